// File: rtl/core/nsbp_pkg.sv
// nsbp_pkg: shared types and constants of the nmea sentence byte parser
// no dependencies; imported by nsbp_tagger and nmea_sentence_byte_parser_top

package nsbp_pkg;

	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 3;
	localparam int IDX_W   = 5;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;
	localparam int DATA_W  = 24;

	localparam logic [BYTE_W-1:0] BYTE_START = 8'h24;
	localparam logic [BYTE_W-1:0] BYTE_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] BYTE_STAR  = 8'h2A;
	localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;

	localparam int CHECKSUM_CHARS = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_IGNORED  = 3'd0,
		KIND_COMMAND  = 3'd1,
		KIND_FIELD    = 3'd2,
		KIND_CHECKSUM = 3'd3,
		KIND_END      = 3'd4
	} kind_t;

	typedef enum logic [4:0] {
		MODE_WAIT     = 5'b00001,
		MODE_COMMAND  = 5'b00010,
		MODE_FIELDS   = 5'b00100,
		MODE_CHECKSUM = 5'b01000,
		MODE_TERM     = 5'b10000
	} mode_t;

	typedef struct packed {
		kind_t               kind;
		logic [IDX_W-1:0]    field_index;
		logic [POS_W-1:0]    char_pos;
		logic [BYTE_W-1:0]   char_value;
		logic [COUNT_W-1:0]  field_count;
		logic                terminator_ok;
	} result_t;

endpackage

// File: rtl/core/nsbp_tagger.sv
// nsbp_tagger: sentence state machine that tags one byte per step
// depends on nsbp_pkg; state advances only when step is high

module nsbp_tagger #(
	parameter int COMMAND_CHARS   = 5,
	parameter int MAX_FIELDS      = 20,
	parameter int MAX_FIELD_CHARS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	output nsbp_pkg::result_t      res
);
	import nsbp_pkg::*;

	localparam int CMAX = (COMMAND_CHARS > MAX_FIELD_CHARS) ? COMMAND_CHARS : MAX_FIELD_CHARS;
	localparam int CW   = $clog2(CMAX);
	localparam int FW   = $clog2(MAX_FIELDS);

	mode_t          mode_q, mode_d;
	logic [CW-1:0]  char_count_q, char_count_d;
	logic [FW-1:0]  field_count_q, field_count_d;
	logic           first_term_ok_q, first_term_ok_d;

	always_comb begin
		mode_d          = mode_q;
		char_count_d    = char_count_q;
		field_count_d   = field_count_q;
		first_term_ok_d = first_term_ok_q;
		res             = '0;
		res.kind        = KIND_IGNORED;
		res.char_value  = data_byte;
		unique case (mode_q)
			MODE_WAIT: begin
				if (data_byte == BYTE_START) begin
					mode_d          = MODE_COMMAND;
					char_count_d    = '0;
					field_count_d   = '0;
					first_term_ok_d = 1'b0;
				end
			end
			MODE_COMMAND: begin
				if (data_byte != BYTE_COMMA) begin
					res.kind     = KIND_COMMAND;
					res.char_pos = POS_W'(char_count_q);
					if (char_count_q == CW'(COMMAND_CHARS - 1)) begin
						mode_d        = MODE_FIELDS;
						field_count_d = '0;
						char_count_d  = '0;
					end else begin
						char_count_d = char_count_q + 1'b1;
					end
				end
			end
			MODE_FIELDS: begin
				if (data_byte == BYTE_COMMA) begin
					// field index wraps at the field limit
					if (field_count_q == FW'(MAX_FIELDS - 1))
						field_count_d = '0;
					else
						field_count_d = field_count_q + 1'b1;
					char_count_d = '0;
				end else if (data_byte == BYTE_STAR) begin
					mode_d       = MODE_CHECKSUM;
					char_count_d = '0;
				end else if (field_count_q != '0) begin
					res.kind        = KIND_FIELD;
					res.field_index = IDX_W'(field_count_q - 1'b1);
					res.char_pos    = POS_W'(char_count_q);
					if (char_count_q == CW'(MAX_FIELD_CHARS - 1))
						char_count_d = '0;
					else
						char_count_d = char_count_q + 1'b1;
				end
			end
			MODE_CHECKSUM: begin
				res.kind     = KIND_CHECKSUM;
				res.char_pos = POS_W'(char_count_q);
				if (char_count_q == CW'(CHECKSUM_CHARS - 1)) begin
					mode_d       = MODE_TERM;
					char_count_d = '0;
				end else begin
					char_count_d = char_count_q + 1'b1;
				end
			end
			MODE_TERM: begin
				if (char_count_q == '0) begin
					first_term_ok_d = (data_byte == BYTE_CR);
					char_count_d    = CW'(1);
				end else begin
					res.kind          = KIND_END;
					res.field_count   = COUNT_W'(field_count_q);
					res.terminator_ok = first_term_ok_q && (data_byte == BYTE_LF);
					mode_d            = MODE_WAIT;
					char_count_d      = '0;
				end
			end
			default: begin
				mode_d       = MODE_WAIT;
				char_count_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_WAIT;
			char_count_q    <= '0;
			field_count_q   <= '0;
			first_term_ok_q <= 1'b0;
		end else if (step) begin
			mode_q          <= mode_d;
			char_count_q    <= char_count_d;
			field_count_q   <= field_count_d;
			first_term_ok_q <= first_term_ok_d;
		end
	end

endmodule

// File: rtl/core/nmea_sentence_byte_parser_top.sv
// nmea_sentence_byte_parser_top: byte tagger for nmea style sentences
// depends on nsbp_pkg and nsbp_tagger
//
//   channel   dir   payload
//   s_axis    in    tdata[7:0] data_byte
//   m_axis    out   tuser kind, tdata field_index .. terminator_ok
//
// one byte in, one tagged result out, through the input register and the result register
// a new byte can be taken every cycle while m_axis is not stalled; input register feeds the tagger,
// the result register holds the tag until it is taken
// a stall on m_axis holds both registers and drops s_axis_tready when full
// reset clears the sentence state and both valid flags

module nmea_sentence_byte_parser_top #(
	parameter int COMMAND_CHARS   = 5,
	parameter int MAX_FIELDS      = 20,
	parameter int MAX_FIELD_CHARS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [4:0] field_index, [8:5] char_pos, [16:9] char_value,
	// [21:17] field_count, [22] terminator_ok, [23] zero
	output logic [nsbp_pkg::DATA_W-1:0]   m_axis_tdata,
	output logic [nsbp_pkg::KIND_W-1:0]   m_axis_tuser    // [2:0] kind
);
	import nsbp_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	result_t           res_s2;
	result_t           res;
	logic              adv_s2;
	logic              adv_s1;

	// result register frees when empty or taken this cycle
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	nsbp_tagger #(
		.COMMAND_CHARS   (COMMAND_CHARS),
		.MAX_FIELDS      (MAX_FIELDS),
		.MAX_FIELD_CHARS (MAX_FIELD_CHARS)
	) u_tagger (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.data_byte (byte_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			byte_s1 <= s_axis_tdata;
		if (adv_s1)
			res_s2 <= res;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tdata  = {1'b0, res_s2.terminator_ok, res_s2.field_count,
	                        res_s2.char_value, res_s2.char_pos, res_s2.field_index};

endmodule
